FILE: hw/rtl/t9pd_pkg.sv
`timescale 1ns / 1ps
// Package for the type 9 password decoder: key alphabet lookup, group schedule,
// weight shifts, decoder phase and status codes. No dependencies.

package t9pd_pkg;

   localparam int KEY_LEN = 65;
   localparam int CYCLE_LEN = 7;
   localparam int MAX_GROUP = 4;

   // key alphabet, first character in the most significant byte
   localparam logic [8*KEY_LEN-1:0] KEY_STR =
      "QzF3n6/9CAtpu0OB1IREhcSyrleKvMW8LXx7N-dVbwsY2g4oaJZGUDjiHkq.mPf5T";

   // group sizes of the 7-step cycle
   localparam logic [2:0] GROUP_SIZE [CYCLE_LEN] =
      '{3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd4, 3'd3};

   // weights are powers of two; stored as shift amounts
   localparam logic [2:0] WEIGHT_SHIFT [CYCLE_LEN][MAX_GROUP] = '{
      '{3'd0, 3'd2, 3'd5, 3'd0},
      '{3'd0, 3'd4, 3'd5, 3'd0},
      '{3'd0, 3'd3, 3'd5, 3'd0},
      '{3'd0, 3'd6, 3'd0, 3'd0},
      '{3'd0, 3'd5, 3'd0, 3'd0},
      '{3'd0, 3'd2, 3'd4, 3'd7},
      '{3'd0, 3'd5, 3'd6, 3'd0}
   };

   localparam logic [7:0] CHAR_MAX = 8'd127;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_SHORT   = 2'd2,
      STATUS_RANGE   = 2'd3
   } t9pd_status_type;

   typedef enum logic [1:0] {
      PH_FIRST = 2'd0,
      PH_SALT  = 2'd1,
      PH_GROUP = 2'd2,
      PH_DRAIN = 2'd3
   } t9pd_phase_type;

   // one looked-up input character
   typedef struct packed {
      logic       hit;
      logic [6:0] idx;
      logic       last;
   } t9pd_item_type;

   function automatic logic [7:0] key_char(input int i);
      return KEY_STR[8*(KEY_LEN-1-i) +: 8];
   endfunction

   function automatic logic [7:0] key_lookup(input logic [7:0] c);
      logic [7:0] r;
      r = 8'd0;
      for (int i = 0; i < KEY_LEN; i++) begin
         if (key_char(i) == c) begin
            r = {1'b1, 7'(i)};
         end
      end
      return r;
   endfunction

   function automatic logic [1:0] salt_count(input logic [6:0] idx);
      logic [1:0] r;
      if (idx <= 7'd14) r = 2'd3;
      else if (idx <= 7'd34) r = 2'd2;
      else if (idx <= 7'd54) r = 2'd1;
      else r = 2'd0;
      return r;
   endfunction

endpackage

FILE: hw/rtl/t9pd_lookup.sv
`timescale 1ns / 1ps
// Input stage: registers each incoming character with its alphabet index.
// Depends on t9pd_pkg.

module t9pd_lookup import t9pd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] ch
   input  logic          req_tlast,
   output logic          item_valid,
   input  logic          item_ready,
   output t9pd_item_type item
);

   logic          item_valid_ff, item_valid_in;
   t9pd_item_type item_ff, item_in;
   logic [7:0]    hit_idx;
   logic          take;

   assign req_tready = !item_valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;
   assign hit_idx    = key_lookup(req_tdata);

   always_comb begin
      item_in.hit  = hit_idx[7];
      item_in.idx  = hit_idx[6:0];
      item_in.last = req_tlast;
      if (take) item_valid_in = 1'b1;
      else if (item_ready) item_valid_in = 1'b0;
      else item_valid_in = item_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

FILE: hw/rtl/t9pd_core.sv
`timescale 1ns / 1ps
// Decode state (phase, salt, group schedule, accumulator, error) and the
// result register. Depends on t9pd_pkg.

module t9pd_core import t9pd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   output logic          item_ready,
   input  t9pd_item_type item,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata,   // [6:0] out_char, [8:7] status, rest zero
   output logic          rsp_tlast,   // finished
   output logic          rsp_tuser    // char_valid
);

   t9pd_phase_type phase_ff, phase_in;
   logic [1:0] salt_ff, salt_in;
   logic [2:0] pat_ff, pat_in;
   logic [1:0] gpos_ff, gpos_in;
   logic [6:0] prev_ff, prev_in;
   logic [7:0] acc_ff, acc_in;
   logic [1:0] err_ff, err_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] char_ff, char_in;
   logic       cvalid_ff, cvalid_in;
   logic       fin_ff, fin_in;
   logic [1:0] status_ff, status_in;

   logic       step, emit, clear;
   logic [1:0] salt_dec;
   logic [6:0] span;
   logic [7:0] gap, weighted, acc_sum;
   logic [2:0] gpos_inc;

   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign step       = item_valid && item_ready;

   // gap = ((65 + idx - prev) mod 65) - 1, wrapped; both indexes are below 65
   always_comb begin
      if (item.idx >= prev_ff) span = item.idx - prev_ff;
      else span = 7'(8'(item.idx) + 8'(KEY_LEN) - 8'(prev_ff));
      gap      = 8'(span) - 8'd1;
      weighted = gap << WEIGHT_SHIFT[pat_ff][gpos_ff];
      acc_sum  = acc_ff + weighted;
      salt_dec = salt_ff - 2'd1;
      gpos_inc = 3'(gpos_ff) + 3'd1;
   end

   always_comb begin
      phase_in  = phase_ff;
      salt_in   = salt_ff;
      pat_in    = pat_ff;
      gpos_in   = gpos_ff;
      prev_in   = prev_ff;
      acc_in    = acc_ff;
      err_in    = err_ff;
      emit      = 1'b0;
      clear     = 1'b0;
      char_in   = 7'd0;
      cvalid_in = 1'b0;
      fin_in    = 1'b0;
      status_in = STATUS_OK;

      unique case (phase_ff)
         PH_FIRST: begin
            if (!item.hit) begin
               err_in    = STATUS_INVALID;
               phase_in  = PH_DRAIN;
               status_in = STATUS_INVALID;
            end else begin
               prev_in   = item.idx;
               salt_in   = salt_count(item.idx);
               if (salt_count(item.idx) != 2'd0) phase_in = PH_SALT;
               else phase_in = PH_GROUP;
               status_in = STATUS_SHORT;
            end
            emit = item.last;
         end
         PH_SALT: begin
            salt_in = salt_dec;
            if (salt_dec == 2'd0) phase_in = PH_GROUP;
            status_in = (salt_dec != 2'd0) ? STATUS_SHORT : STATUS_OK;
            emit      = item.last;
         end
         PH_GROUP: begin
            if (!item.hit) begin
               if (err_ff == STATUS_OK) err_in = STATUS_INVALID;
            end else if (err_ff == STATUS_OK) begin
               acc_in  = acc_sum;
               prev_in = item.idx;
            end
            if (gpos_inc < GROUP_SIZE[pat_ff]) begin
               gpos_in   = gpos_inc[1:0];
               status_in = STATUS_SHORT;
               emit      = item.last;
            end else begin
               gpos_in = 2'd0;
               if (err_in != STATUS_OK) begin
                  phase_in  = PH_DRAIN;
                  status_in = err_in;
                  emit      = item.last;
               end else if (acc_in > CHAR_MAX) begin
                  err_in    = STATUS_RANGE;
                  phase_in  = PH_DRAIN;
                  status_in = STATUS_RANGE;
                  emit      = item.last;
               end else begin
                  // completed group: one plain character
                  emit      = 1'b1;
                  char_in   = acc_in[6:0];
                  cvalid_in = 1'b1;
                  pat_in    = (pat_ff == 3'(CYCLE_LEN - 1)) ? 3'd0 : pat_ff + 3'd1;
                  acc_in    = 8'd0;
               end
            end
         end
         PH_DRAIN: begin
            status_in = err_ff;
            emit      = item.last;
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      if (item.last) begin
         fin_in = 1'b1;
         clear  = 1'b1;
      end
      if (cvalid_in) status_in = STATUS_OK;
   end

   always_comb begin
      if (step) rsp_valid_in = emit;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         salt_ff      <= 2'd0;
         pat_ff       <= 3'd0;
         gpos_ff      <= 2'd0;
         prev_ff      <= 7'd0;
         acc_ff       <= 8'd0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            if (clear) begin
               phase_ff <= PH_FIRST;
               salt_ff  <= 2'd0;
               pat_ff   <= 3'd0;
               gpos_ff  <= 2'd0;
               prev_ff  <= 7'd0;
               acc_ff   <= 8'd0;
               err_ff   <= STATUS_OK;
            end else begin
               phase_ff <= phase_in;
               salt_ff  <= salt_in;
               pat_ff   <= pat_in;
               gpos_ff  <= gpos_in;
               prev_ff  <= prev_in;
               acc_ff   <= acc_in;
               err_ff   <= err_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         char_ff   <= char_in;
         cvalid_ff <= cvalid_in;
         fin_ff    <= fin_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, status_ff, char_ff};
   assign rsp_tlast  = fin_ff;
   assign rsp_tuser  = cvalid_ff;

endmodule

FILE: hw/rtl/type9_password_decoder.sv
`timescale 1ns / 1ps
// Type 9 password decoder, one encoded character per transaction.
// Two register stages: the lookup stage registers the accepted character, then the
// state/result stage registers the result that rsp_tvalid presents.
// Throughput: one character per cycle; the state update stage in t9pd_core
// takes one item each cycle that its result register can take a result.
// Reset (synchronous, active high) empties both stages and returns to the first character.

module type9_password_decoder import t9pd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] out_char, [8:7] status, [15:9] zero
   output logic        rsp_tlast,   // finished
   output logic        rsp_tuser    // char_valid
);

   logic          item_valid;
   logic          item_ready;
   t9pd_item_type item;

   t9pd_lookup u_lookup (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   t9pd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: hw/rtl/t9pd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for type9_password_decoder, bound to the top level.
// Depends on the top level's port list only.

module t9pd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // a result that does not close the string must carry a character
   a_mid_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser)
      else $error("non-final result without character");

   // a decoded character always reports ok status
   a_char_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[8:7] == 2'd0)
      else $error("character result with error status");

   // no character means a zero character field
   a_nochar_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[6:0] == 7'd0)
      else $error("status-only result with nonzero character");

   // nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind type9_password_decoder t9pd_checker u_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for type9_password_decoder: directed strings, then random
// encoded strings checked against a behavioral decoder. Needs t9pd_pkg and the RTL.

module testbench;
   import t9pd_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam int CODE_LEN = 65;
   localparam int TOTAL_CHARS = 950;
   localparam int DIRECTED_ROWS = 25;
   localparam int PRESSURE_HOLD = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES = 8;

   localparam logic [8*CODE_LEN-1:0] CODE_SET =
      "QzF3n6/9CAtpu0OB1IREhcSyrleKvMW8LXx7N-dVbwsY2g4oaJZGUDjiHkq.mPf5T";
   localparam int GROUP_LEN [7] = '{3, 3, 3, 2, 2, 4, 3};
   localparam int GROUP_WEIGHT [7][4] = '{
      '{1, 4, 32, 0}, '{1, 16, 32, 0}, '{1, 8, 32, 0}, '{1, 64, 0, 0},
      '{1, 32, 0, 0}, '{1, 4, 16, 128}, '{1, 32, 64, 0}
   };

   typedef struct packed {
      logic [6:0]      out_char;
      logic            char_valid;
      logic            finished;
      t9pd_status_type status;
   } decode_result_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       typed;
      logic [6:0] want_char;
      logic       want_valid;
      logic       want_fin;
      logic [1:0] want_status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;   // [7:0] ch
   logic req_tlast;         // last
   logic rsp_tvalid;
   logic rsp_tready;
   logic [15:0] rsp_tdata;  // [6:0] out_char, [8:7] status, [15:9] zero
   logic rsp_tlast;         // finished
   logic rsp_tuser;         // char_valid

   type9_password_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // decoder state mirrored by the bench
   t9pd_phase_type  dec_phase;
   t9pd_status_type err_code;
   logic [1:0]      salt_left;
   int              pattern_idx;
   int              group_pos;
   int              prev_idx;
   logic [7:0]      acc;

   decode_result_type expected_decodes [$];
   logic [7:0]        string_bytes [$];
   stim_row_type      directed_rows [DIRECTED_ROWS];
   int mismatches = 0;
   int fed_chars = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   bit pressure_go = 1'b0;
   bit pressure_done = 1'b0;

   function automatic logic [7:0] code_char(input int i);
      return CODE_SET[8*(CODE_LEN-1-i) +: 8];
   endfunction

   function automatic bit code_index(input logic [7:0] ch, output int pos);
      pos = 0;
      for (int i = 0; i < CODE_LEN; i++) begin
         if (code_char(i) == ch) begin
            pos = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic int salts_for(input int pos);
      if (pos <= 14) return 3;
      if (pos <= 34) return 2;
      if (pos <= 54) return 1;
      return 0;
   endfunction

   function automatic void clear_decoder();
      dec_phase = PH_FIRST;
      err_code = STATUS_OK;
      salt_left = 2'd0;
      pattern_idx = 0;
      group_pos = 0;
      prev_idx = 0;
      acc = 8'd0;
   endfunction

   function automatic void close_string(output decode_result_type res,
                                        input t9pd_status_type st);
      res = '0;
      res.finished = 1'b1;
      res.status = st;
      clear_decoder();
   endfunction

   // returns 1 when the character produces a result transaction
   function automatic bit decode_step(input logic [7:0] ch, input logic last,
                                      output decode_result_type res);
      int pos;
      int d;
      int g;
      bit hit;
      bit got;
      logic [7:0] gap;
      got = 1'b0;
      res = '0;
      hit = code_index(ch, pos);
      case (dec_phase)
         PH_FIRST: begin
            if (!hit) begin
               err_code = STATUS_INVALID;
               dec_phase = PH_DRAIN;
               if (last) begin
                  close_string(res, STATUS_INVALID);
                  got = 1'b1;
               end
            end else begin
               prev_idx = pos;
               salt_left = 2'(salts_for(pos));
               if (salt_left != 2'd0) dec_phase = PH_SALT;
               else dec_phase = PH_GROUP;
               if (last) begin
                  close_string(res, STATUS_SHORT);
                  got = 1'b1;
               end
            end
         end
         PH_SALT: begin
            salt_left = salt_left - 2'd1;
            if (salt_left == 2'd0) dec_phase = PH_GROUP;
            if (last) begin
               if (salt_left != 2'd0) close_string(res, STATUS_SHORT);
               else close_string(res, STATUS_OK);
               got = 1'b1;
            end
         end
         PH_GROUP: begin
            g = group_pos;
            if (!hit) begin
               if (err_code == STATUS_OK) err_code = STATUS_INVALID;
            end else if (err_code == STATUS_OK) begin
               d = (CODE_LEN + pos - prev_idx) % CODE_LEN;
               gap = 8'(d - 1);
               acc = 8'(acc + gap * GROUP_WEIGHT[pattern_idx][g]);
               prev_idx = pos;
            end
            g++;
            if (g < GROUP_LEN[pattern_idx]) begin
               group_pos = g;
               if (last) begin
                  close_string(res, STATUS_SHORT);
                  got = 1'b1;
               end
            end else begin
               group_pos = 0;
               if (err_code != STATUS_OK) begin
                  dec_phase = PH_DRAIN;
                  if (last) begin
                     close_string(res, err_code);
                     got = 1'b1;
                  end
               end else if (acc > 8'd127) begin
                  err_code = STATUS_RANGE;
                  dec_phase = PH_DRAIN;
                  if (last) begin
                     close_string(res, STATUS_RANGE);
                     got = 1'b1;
                  end
               end else begin
                  res.out_char = acc[6:0];
                  res.char_valid = 1'b1;
                  res.finished = last;
                  res.status = STATUS_OK;
                  got = 1'b1;
                  pattern_idx = (pattern_idx + 1) % 7;
                  acc = 8'd0;
                  if (last) clear_decoder();
               end
            end
         end
         default: begin
            if (last) begin
               close_string(res, err_code);
               got = 1'b1;
            end
         end
      endcase
      return got;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < 40)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // called at a rising edge; returns at the edge where the transaction is taken
   task automatic send_char(input logic [7:0] ch, input logic last, input bit typed,
                            input decode_result_type want);
      decode_result_type res;
      bit got;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      fed_chars++;
      got = decode_step(ch, last, res);
      if (typed) begin
         got = 1'b1;
         res = want;
      end
      if (got) expected_decodes = {expected_decodes, res};
   endtask

   function automatic int random_gap();
      if ($urandom_range(9) == 0) return 255;   // repeated character
      return $urandom_range(63);
   endfunction

   // one encoded string: mostly well-formed with legal group sums, some noise
   task automatic build_string();
      int kind;
      int first;
      int prev;
      int p;
      int sum;
      int target;
      int tries;
      int n;
      int gaps [4];
      string_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(1) == 1)
               string_bytes = {string_bytes, code_char($urandom_range(64))};
            else string_bytes = {string_bytes, 8'($urandom)};
         end
         return;
      end
      first = $urandom_range(CODE_LEN - 1);
      string_bytes = {string_bytes, code_char(first)};
      repeat (salts_for(first)) string_bytes = {string_bytes, 8'($urandom)};
      prev = first;
      p = 0;
      repeat ($urandom_range(9)) begin
         if (kind < 20) begin
            // unconstrained gaps, sums often out of range
            for (int g = 0; g < GROUP_LEN[p]; g++) gaps[g] = random_gap();
         end else begin
            target = $urandom_range(127);
            tries = 0;
            do begin
               sum = 0;
               for (int g = 1; g < GROUP_LEN[p]; g++) begin
                  gaps[g] = random_gap();
                  sum += gaps[g] * GROUP_WEIGHT[p][g];
               end
               gaps[0] = (target - sum) & 255;
               tries++;
            end while (!(gaps[0] <= 63 || gaps[0] == 255) && tries < 40);
            if (!(gaps[0] <= 63 || gaps[0] == 255)) gaps[0] = $urandom_range(63);
         end
         for (int g = 0; g < GROUP_LEN[p]; g++) begin
            prev = (prev + ((gaps[g] + 1) & 255)) % CODE_LEN;
            string_bytes = {string_bytes, code_char(prev)};
         end
         p = (p + 1) % 7;
      end
      if (kind < 35) begin
         if ($urandom_range(1) == 1) begin
            n = $urandom_range(1, string_bytes.size());
            while (string_bytes.size() > n) void'(string_bytes.pop_back());
         end else begin
            string_bytes[$urandom_range(string_bytes.size() - 1)] = 8'($urandom);
         end
      end
   endtask

   // result side
   initial begin
      decode_result_type want;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_decodes.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_tdata, 0);
            end else begin
               want = expected_decodes.pop_front();
               if (rsp_tdata[6:0] != want.out_char)
                  report_mismatch("out_char", rsp_tdata[6:0], want.out_char);
               if (rsp_tdata[8:7] != want.status)
                  report_mismatch("status", rsp_tdata[8:7], want.status);
               if (rsp_tlast != want.finished)
                  report_mismatch("finished", rsp_tlast, want.finished);
               if (rsp_tuser != want.char_valid)
                  report_mismatch("char_valid", rsp_tuser, want.char_valid);
            end
         end
         if (pressure_go && !pressure_done) begin
            // long back-pressure so the decoder fills and stalls its input
            rsp_tready <= 1'b0;
            for (int i = 0; i < PRESSURE_HOLD; i++) @(posedge clock);
            pressure_done = 1'b1;
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int seg;
      decode_result_type want;
      directed_rows = '{
         '{8'hFF, 1'b1, 1'b1, 7'd0, 1'b0, 1'b1, STATUS_INVALID},  // bad first character
         '{"Q",   1'b1, 1'b1, 7'd0, 1'b0, 1'b1, STATUS_SHORT},    // one-character string
         '{"T",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},       // no salt, all gaps zero
         '{"Q",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{"z",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{"F",   1'b1, 1'b1, 7'd0, 1'b1, 1'b1, STATUS_OK},
         '{"Q",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},       // three salt bytes, any value
         '{8'h00, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{8'hFF, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{8'h80, 1'b1, 1'b1, 7'd0, 1'b0, 1'b1, STATUS_OK},       // ends right after salt
         '{"Q",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{8'h00, 1'b1, 1'b1, 7'd0, 1'b0, 1'b1, STATUS_SHORT},    // ends inside salt
         '{"T",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{"Q",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{"!",   1'b1, 1'b1, 7'd0, 1'b0, 1'b1, STATUS_SHORT},    // bad char, group unfinished
         '{"T",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{"!",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},       // bad char, group completes
         '{"Q",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{"z",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{8'h00, 1'b1, 1'b1, 7'd0, 1'b0, 1'b1, STATUS_INVALID},
         '{"T",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},       // group sum 220
         '{"Q",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{"Q",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{"Q",   1'b0, 1'b0, 7'd0, 1'b0, 1'b0, STATUS_OK},
         '{"F",   1'b1, 1'b1, 7'd0, 1'b0, 1'b1, STATUS_RANGE}
      };
      clear_decoder();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tlast = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         want.out_char = directed_rows[i].want_char;
         want.char_valid = directed_rows[i].want_valid;
         want.finished = directed_rows[i].want_fin;
         want.status = t9pd_status_type'(directed_rows[i].want_status);
         send_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed, want);
      end

      while (fed_chars < TOTAL_CHARS) begin
         seg = fed_chars * 5 / TOTAL_CHARS;
         case (seg)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
               if (fed_chars >= 60) pressure_go = 1'b1;
            end
            1: begin
               send_idle_pct = 76;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 76;
            end
            3: begin
               send_idle_pct = 16;
               stall_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
         endcase
         build_string();
         for (int i = 0; i < string_bytes.size(); i++)
            send_char(string_bytes[i], 1'(i == string_bytes.size() - 1), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_decodes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/t9pd_pkg.sv
hw/rtl/t9pd_lookup.sv
hw/rtl/t9pd_core.sv
hw/rtl/type9_password_decoder.sv
hw/rtl/t9pd_checker.sv
bench/testbench.sv
